// ----- hdl/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// Used by spq_cell, sorted_priority_queue and spq_checker; depends on nothing.
package spq_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OCC_W  = 5;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_PEEK    = 2'd1,
        OP_EXTRACT = 2'd2
    } op_t;

    // One stored entry.
    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] pay;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   ins;
        logic   ext;
        entry_t item;
    } cell_ctl_t;

endpackage

// ----- hdl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  logic               left_gt,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               gt
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // A slot is "greater" when it is empty or its priority is strictly above
    // the new one, so equal priorities keep arrival order.
    assign gt    = !occupied || (entry_reg.prio > ctl.item.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && gt)
        begin
            entry_next = left_gt ? left_entry : ctl.item;
        end
        else if (ctl.ext)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- hdl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a chain of spq_cell slots plus
// the fill count and the output word register. Depends on spq_pkg, spq_cell.

// The queue holds up to CAPACITY entries in ascending priority order in a
// row of cells; slot 0 is always the front. Every cell compares its own
// priority with the new one at the same time, so an insert, peek or extract
// needs no iteration: a word is accepted in every cycle, the result word
// appears in the output register in the cycle after acceptance, and input
// is held back only while a finished result waits on out_ready. Equal
// priorities leave in arrival order. Peek or extract on an empty queue
// returns payload 0 with was_empty set; an insert into a full queue is
// dropped with dropped_full set. Opcode 3 does nothing and reports the
// current occupancy. Occupancy carries the low five bits of the count.
// Entries need no clearing after reset; only the count and out_valid are reset.
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic signed [spq_pkg::DATA_W-1:0]   priority_req,
    input  logic signed [spq_pkg::DATA_W-1:0]   payload,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [spq_pkg::DATA_W-1:0]   min_payload,
    output logic                                was_empty,
    output logic                                dropped_full,
    output logic [spq_pkg::OCC_W-1:0]           occupancy
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                              out_valid_reg;
    logic signed [spq_pkg::DATA_W-1:0] min_payload_reg;
    logic signed [spq_pkg::DATA_W-1:0] min_payload_next;
    logic                              was_empty_reg;
    logic                              was_empty_next;
    logic                              dropped_full_reg;
    logic                              dropped_full_next;
    logic [spq_pkg::OCC_W-1:0]         occupancy_reg;
    logic [CW+spq_pkg::OCC_W-1:0]      occ_wide;

    logic              in_fire;
    logic              is_empty;
    logic              is_full;
    spq_pkg::cell_ctl_t ctl;

    spq_pkg::entry_t entries [CAPACITY];
    logic            gts     [CAPACITY];

    // The input side is free whenever the output register is empty or being
    // drained in this same cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == FULL_COUNT);

    // Decode the word into the command seen by every cell, and form the
    // result and the new count.
    always_comb
    begin
        ctl.ins           = 1'b0;
        ctl.ext           = 1'b0;
        ctl.item.prio     = priority_req;
        ctl.item.pay      = payload;
        count_next        = count_reg;
        min_payload_next  = '0;
        was_empty_next    = 1'b0;
        dropped_full_next = 1'b0;
        case (spq_pkg::op_t'(opcode))
            spq_pkg::OP_INSERT:
            begin
                if (is_full)
                begin
                    dropped_full_next = 1'b1;
                end
                else
                begin
                    ctl.ins    = in_fire;
                    count_next = count_reg + 1'b1;
                end
            end
            spq_pkg::OP_PEEK:
            begin
                if (is_empty)
                begin
                    was_empty_next = 1'b1;
                end
                else
                begin
                    min_payload_next = entries[0].pay;
                end
            end
            spq_pkg::OP_EXTRACT:
            begin
                if (is_empty)
                begin
                    was_empty_next = 1'b1;
                end
                else
                begin
                    min_payload_next = entries[0].pay;
                    ctl.ext          = in_fire;
                    count_next       = count_reg - 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, count_next};

    // The chain: each cell sees the "greater" flag and entry of its left
    // neighbor for inserts and the entry of its right neighbor for extracts.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic            occupied;
        logic            left_gt;
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;

        assign occupied = (count_reg > IDX);

        if (i == 0)
        begin : g_first
            assign left_gt    = 1'b0;
            assign left_entry = ctl.item;
        end
        else
        begin : g_inner
            assign left_gt    = gts[i-1];
            assign left_entry = entries[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            // The vacated tail slot lies beyond the count after an extract.
            assign right_entry = entries[i];
        end
        else
        begin : g_body
            assign right_entry = entries[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (occupied),
            .left_gt     (left_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .gt          (gts[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                count_reg <= count_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    // Result word registers carry no reset; out_valid qualifies them.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            min_payload_reg  <= min_payload_next;
            was_empty_reg    <= was_empty_next;
            dropped_full_reg <= dropped_full_next;
            occupancy_reg    <= occ_wide[spq_pkg::OCC_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign min_payload  = min_payload_reg;
    assign was_empty    = was_empty_reg;
    assign dropped_full = dropped_full_reg;
    assign occupancy    = occupancy_reg;

endmodule

// ----- hdl/spq_checker.sv -----
// Port-level checks for sorted_priority_queue, attached by bind.
// Depends on spq_pkg.
module spq_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [spq_pkg::DATA_W-1:0] min_payload,
    input logic                              was_empty,
    input logic                              dropped_full,
    input logic [spq_pkg::OCC_W-1:0]         occupancy
);

    localparam logic [spq_pkg::OCC_W-1:0] OCC_FULL = spq_pkg::OCC_W'(CAPACITY);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_payload) && $stable(occupancy))
        else $error("result word changed while stalled");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_empty && dropped_full))
        else $error("empty and full flags raised together");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_empty |-> min_payload == '0 && occupancy == '0)
        else $error("empty result carries data or occupancy");

    a_drop_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped_full |-> min_payload == '0 && occupancy == OCC_FULL)
        else $error("dropped insert reports wrong payload or occupancy");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .min_payload  (min_payload),
    .was_empty    (was_empty),
    .dropped_full (dropped_full),
    .occupancy    (occupancy)
);

// ----- bench/tb_top.sv -----
// Self-checking testbench for sorted_priority_queue: directed, full-queue, random, backpressure and full-rate tests.
// Depends on spq_pkg and on the RTL of sorted_priority_queue, with its spq_cell.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY    = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned REPORT_MAX  = 10;

    // Opcode 3 is not part of op_t; the block treats it as a no-op.
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic signed [spq_pkg::DATA_W-1:0] PRIO_MIN = 32'sh8000_0000;
    localparam logic signed [spq_pkg::DATA_W-1:0] PRIO_MAX = 32'sh7fff_ffff;

    // One result word as the block should produce it.
    typedef struct packed {
        logic signed [spq_pkg::DATA_W-1:0] pay;
        logic                              empty;
        logic                              dropped;
        logic [spq_pkg::OCC_W-1:0]         occ;
    } outcome_t;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_ready;
    logic [1:0]                        opcode;
    logic signed [spq_pkg::DATA_W-1:0] priority_req;
    logic signed [spq_pkg::DATA_W-1:0] payload;
    logic                              out_valid;
    logic                              out_ready;
    logic signed [spq_pkg::DATA_W-1:0] min_payload;
    logic                              was_empty;
    logic                              dropped_full;
    logic [spq_pkg::OCC_W-1:0]         occupancy;

    sorted_priority_queue #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .priority_req (priority_req),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .min_payload  (min_payload),
        .was_empty    (was_empty),
        .dropped_full (dropped_full),
        .occupancy    (occupancy)
    );

    // Shadow copy of the queue contents, kept sorted the same way as the block.
    logic signed [spq_pkg::DATA_W-1:0] shadow_prio [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] shadow_pay  [CAPACITY];
    int unsigned                       shadow_count;

    // Results predicted at input acceptance, oldest first.
    outcome_t    awaited_outcomes [$];
    int unsigned pending;

    // Knobs the tests turn to shape the traffic on both sides.
    bit          gaps_on;
    bit          stalls_on;
    int unsigned hold_left;

    // Bookkeeping for the final summary and the verdict.
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned words_in;
    int unsigned results_out;
    int unsigned inserts_seen;
    int unsigned peeks_seen;
    int unsigned extracts_seen;
    int unsigned noops_seen;
    int unsigned drops_seen;
    int unsigned empties_seen;
    int unsigned peak_fill;
    int unsigned input_stall_cycles;

    // Applies one operation to the shadow queue and returns the result word
    // it must produce. Ties go behind all equal priorities already held.
    function automatic outcome_t apply_to_shadow(logic [1:0] op,
                                                 logic signed [spq_pkg::DATA_W-1:0] prio,
                                                 logic signed [spq_pkg::DATA_W-1:0] pay);
        outcome_t    o;
        int unsigned pos;
        int unsigned i;
        o = '0;
        if (op == spq_pkg::OP_INSERT)
        begin
            if (shadow_count >= CAPACITY)
            begin
                o.dropped = 1'b1;
            end
            else
            begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
                for (i = shadow_count; i > pos; i--)
                begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_pay[i]  = shadow_pay[i-1];
                end
                shadow_prio[pos] = prio;
                shadow_pay[pos]  = pay;
                shadow_count++;
            end
        end
        else if (op == spq_pkg::OP_PEEK || op == spq_pkg::OP_EXTRACT)
        begin
            if (shadow_count == 0)
            begin
                o.empty = 1'b1;
            end
            else
            begin
                o.pay = shadow_pay[0];
                if (op == spq_pkg::OP_EXTRACT)
                begin
                    for (i = 1; i < shadow_count; i++)
                    begin
                        shadow_prio[i-1] = shadow_prio[i];
                        shadow_pay[i-1]  = shadow_pay[i];
                    end
                    shadow_count--;
                end
            end
        end
        o.occ = shadow_count[spq_pkg::OCC_W-1:0];
        return o;
    endfunction

    // Free-running 2 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver side. A requested hold keeps out_ready low until hold_left
    // has run down to zero; otherwise it stalls at random when stalls are enabled.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
            begin
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= !(stalls_on && $urandom_range(99) < 20);
            end
        end
    end

    // Monitor and checker, both on the rising edge. The result word taken at
    // this edge belongs to an earlier input word, so it is checked before the
    // input word of this edge is predicted.
    always @(posedge clk)
    begin : monitor
        outcome_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_out++;
                if (awaited_outcomes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result word at cycle %0d", cycle_count);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    pending--;
                    if (min_payload !== want.pay || was_empty !== want.empty ||
                        dropped_full !== want.dropped || occupancy !== want.occ)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"mismatch on result %0d: min_payload %0d/%0d, ",
                                      "was_empty %0b/%0b, dropped_full %0b/%0b, ",
                                      "occupancy %0d/%0d (expected/actual)"},
                                     results_out, want.pay, min_payload,
                                     want.empty, was_empty, want.dropped,
                                     dropped_full, want.occ, occupancy);
                    end
                end
            end
            if (in_valid && !in_ready)
                input_stall_cycles++;
            if (in_valid && in_ready)
            begin
                want = apply_to_shadow(opcode, priority_req, payload);
                awaited_outcomes.push_back(want);
                pending++;
                words_in++;
                case (opcode)
                    spq_pkg::OP_INSERT:  inserts_seen++;
                    spq_pkg::OP_PEEK:    peeks_seen++;
                    spq_pkg::OP_EXTRACT: extracts_seen++;
                    default:             noops_seen++;
                endcase
                if (want.dropped) drops_seen++;
                if (want.empty) empties_seen++;
                if (shadow_count > peak_fill) peak_fill = shadow_count;
            end
        end
    end

    // Offers one word and returns at the edge where it is accepted. Idle
    // cycles may come first, each with a one-in-five chance, during which
    // the fields carry noise.
    task automatic send_word(input logic [1:0] op,
                             input logic signed [spq_pkg::DATA_W-1:0] prio,
                             input logic signed [spq_pkg::DATA_W-1:0] pay);
        if (gaps_on && $urandom_range(99) < 20)
        begin
            @(negedge clk);
            in_valid     <= 1'b0;
            opcode       <= 2'($urandom);
            priority_req <= $urandom;
            payload      <= $urandom;
            while ($urandom_range(99) < 20) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        opcode       <= op;
        priority_req <= prio;
        payload      <= pay;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drops valid and waits until every predicted result has come out.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (3) @(posedge clk);
    endtask

    // Priorities are drawn from full range, from a narrow band that forces
    // ties, or from the extremes.
    function automatic logic signed [spq_pkg::DATA_W-1:0] pick_prio();
        case ($urandom_range(2))
            0:       return $urandom;
            1:       return $urandom_range(6) - 3;
            default:
                case ($urandom_range(3))
                    0:       return PRIO_MIN;
                    1:       return PRIO_MAX;
                    2:       return '0;
                    default: return -1;
                endcase
        endcase
    endfunction

    // Picks an opcode; insert_pct steers the fill level up or down.
    function automatic logic [1:0] pick_op(int unsigned insert_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return OP_NONE;
        if (r < 4 + insert_pct)
            return spq_pkg::OP_INSERT;
        return ($urandom_range(3) == 0) ? spq_pkg::OP_PEEK : spq_pkg::OP_EXTRACT;
    endfunction

    task automatic send_random(int unsigned count, int unsigned insert_pct);
        repeat (count) send_word(pick_op(insert_pct), pick_prio(), $urandom);
    endtask

    // Empty-queue reads, extreme priorities and payloads, equal priorities
    // leaving in arrival order, and the unused opcode.
    task automatic test_directed();
        send_word(spq_pkg::OP_PEEK,    PRIO_MAX, PRIO_MAX);
        send_word(spq_pkg::OP_EXTRACT, PRIO_MIN, PRIO_MIN);
        send_word(OP_NONE,             '0, '0);
        send_word(spq_pkg::OP_INSERT,  PRIO_MAX, PRIO_MIN);
        send_word(spq_pkg::OP_INSERT,  PRIO_MIN, PRIO_MAX);
        send_word(spq_pkg::OP_INSERT,  '0, '0);
        send_word(spq_pkg::OP_INSERT,  -1, -1);
        send_word(spq_pkg::OP_INSERT,  PRIO_MIN, 1);
        send_word(spq_pkg::OP_INSERT,  PRIO_MAX, 2);
        send_word(spq_pkg::OP_PEEK,    '0, '0);
        send_word(OP_NONE,             PRIO_MAX, PRIO_MAX);
        repeat (7) send_word(spq_pkg::OP_EXTRACT, '0, '0);
        send_word(spq_pkg::OP_PEEK,    '0, '0);
        settle();
    endtask

    // Fills the queue past capacity so inserts get dropped, then drains it
    // past empty.
    task automatic test_full();
        repeat (CAPACITY + 3) send_word(spq_pkg::OP_INSERT, pick_prio(), $urandom);
        send_word(spq_pkg::OP_PEEK, '0, '0);
        send_word(OP_NONE, '0, '0);
        repeat (CAPACITY + 2) send_word(spq_pkg::OP_EXTRACT, '0, '0);
        settle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the output register fills and input stalls.
    task automatic test_backpressure();
        hold_left = 80;
        send_random(40, 55);
        settle();
    endtask

    // Runs with a fill, drain or balanced bias picked at random for each run, so
    // the fill level sweeps between empty and full many times.
    task automatic test_random_mix(int unsigned runs);
        int unsigned bias;
        repeat (runs)
        begin
            case ($urandom_range(2))
                0:       bias = 75;
                1:       bias = 20;
                default: bias = 48;
            endcase
            send_random($urandom_range(20, 50), bias);
        end
    endtask

    // Back-to-back words with the receiver always ready.
    task automatic test_full_rate();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_random(200, 50);
        settle();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = spq_pkg::OP_INSERT;
        priority_req = '0;
        payload      = '0;
        shadow_count = 0;
        pending      = 0;
        hold_left    = 0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full();
        test_random_mix(14);
        test_backpressure();
        test_full_rate();
        test_full();
        test_random_mix(12);
        test_backpressure();
        settle();

        $display("%0d words sent (%0d inserts, %0d peeks, %0d extracts, %0d no-ops)",
                 words_in, inserts_seen, peeks_seen, extracts_seen, noops_seen);
        $display({"%0d results checked, %0d inserts dropped on full, %0d empty reads, ",
                  "peak fill %0d, %0d input stall cycles"},
                 results_out, drops_seen, empties_seen, peak_fill, input_stall_cycles);
        if (fail_count == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d failures", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
